// ===== rtl/od666_pkg.sv =====
// ----------------------------------------------------------------------------
// od666_pkg: shared types and constants for the RGB888 to RGB666 ditherer
// Counter widths, register codes, the frame position record and the
// reduced 4x4 ordered dither threshold table.
// ----------------------------------------------------------------------------
package od666_pkg;

	localparam int CNT_W   = 10;   // column/row counters and size registers
	localparam int LEVEL_W = 6;    // output channel level
	localparam int CHAN_W  = 8;    // input channel
	localparam int PIX_W   = 32;   // AARRGGBB word

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;

	localparam logic [CNT_W-1:0] FRAME_WIDTH_RST  = 10'd220;
	localparam logic [CNT_W-1:0] FRAME_HEIGHT_RST = 10'd176;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// position of one pixel within the frame
	typedef struct packed {
		logic [1:0] col_lo;
		logic [1:0] row_lo;
		logic       eor;
		logic       eof;
	} pos_t;

	// Bayer 4x4 entry at (row, col), already shifted right by two
	function automatic logic [1:0] dither_thr(input logic [1:0] row, input logic [1:0] col);
		logic [3:0] val;
		case ({row, col})
			4'd0:    val = 4'd0;
			4'd1:    val = 4'd8;
			4'd2:    val = 4'd2;
			4'd3:    val = 4'd10;
			4'd4:    val = 4'd12;
			4'd5:    val = 4'd4;
			4'd6:    val = 4'd14;
			4'd7:    val = 4'd6;
			4'd8:    val = 4'd3;
			4'd9:    val = 4'd11;
			4'd10:   val = 4'd1;
			4'd11:   val = 4'd9;
			4'd12:   val = 4'd15;
			4'd13:   val = 4'd7;
			4'd14:   val = 4'd13;
			4'd15:   val = 4'd5;
			default: val = 4'd0;
		endcase
		return val[3:2];
	endfunction

endpackage

// ===== rtl/od666_pix_if.sv =====
// ----------------------------------------------------------------------------
// od666_pix_if: input pixel channel
// Valid/ready channel carrying one AARRGGBB pixel word per transfer.
// ----------------------------------------------------------------------------
interface od666_pix_if
	import od666_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_word;

	modport source (output valid, output pixel_word, input ready);
	modport sink   (input valid, input pixel_word, output ready);
endinterface

// ===== rtl/od666_lvl_if.sv =====
// ----------------------------------------------------------------------------
// od666_lvl_if: output level channel
// Valid/ready channel carrying one dithered RGB666 pixel and its row and
// frame marks per transfer.
// ----------------------------------------------------------------------------
interface od666_lvl_if
	import od666_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] blue_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] red_level;
	logic               end_of_row;
	logic               end_of_frame;

	modport source (output valid, output blue_level, output green_level, output red_level,
		output end_of_row, output end_of_frame, input ready);
	modport sink   (input valid, input blue_level, input green_level, input red_level,
		input end_of_row, input end_of_frame, output ready);
endinterface

// ===== rtl/od666_pos.sv =====
// ----------------------------------------------------------------------------
// od666_pos: raster position tracker
// Column and row counters that wrap at the frame size; a size of zero
// counts as 1024. Gives the position record of the pixel now at the input.
// ----------------------------------------------------------------------------
module od666_pos
	import od666_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [CNT_W-1:0] frame_width,
	input  logic [CNT_W-1:0] frame_height,
	output pos_t             pos
);
	logic [CNT_W-1:0] col_q, row_q;
	logic [CNT_W:0]   width_full, height_full;
	logic [CNT_W:0]   col_inc, row_inc;
	logic             eor, eof;

	assign width_full  = (frame_width == '0)  ? (CNT_W+1)'(1 << CNT_W) : {1'b0, frame_width};
	assign height_full = (frame_height == '0) ? (CNT_W+1)'(1 << CNT_W) : {1'b0, frame_height};
	assign col_inc     = {1'b0, col_q} + (CNT_W+1)'(1);
	assign row_inc     = {1'b0, row_q} + (CNT_W+1)'(1);

	// at or past the last position also ends the line (size lowered mid-frame)
	assign eor = col_inc >= width_full;
	assign eof = eor && (row_inc >= height_full);

	assign pos.col_lo = col_q[1:0];
	assign pos.row_lo = row_q[1:0];
	assign pos.eor    = eor;
	assign pos.eof    = eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (eor) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end
endmodule

// ===== rtl/od666_chan.sv =====
// ----------------------------------------------------------------------------
// od666_chan: one channel reducer
// Drops two bits of an 8-bit value and rounds up against the dither
// threshold, saturating at the top level.
// ----------------------------------------------------------------------------
module od666_chan
	import od666_pkg::*;
(
	input  logic [CHAN_W-1:0]  value,
	input  logic [1:0]         thr,
	output logic [LEVEL_W-1:0] level
);
	logic [LEVEL_W-1:0] base;
	logic               raise;

	assign base  = value[CHAN_W-1:2];
	assign raise = (value[1:0] > thr) && (base != LEVEL_MAX);
	assign level = base + LEVEL_W'(raise);
endmodule

// ===== rtl/ordered_dither_rgb666.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_rgb666: 4x4 ordered dither, RGB888 to RGB666
// Streams raster-order pixels and emits dithered 6-bit levels with
// end-of-row and end-of-frame marks.
// ----------------------------------------------------------------------------
// One pixel per clock sustained while the sink keeps up. On its way through,
// the input register captures the pixel together with its frame position,
// and the result register holds the dithered levels until the sink takes
// them. Both stages advance independently, so a new pixel is taken while a
// finished result still waits; pix_in.ready drops only when both stages
// are full and the sink stalls. Frame size is set through cfg_we/cfg_index/
// cfg_data (index 0 width, 1 height, 10 bits, 0 means 1024); reset gives
// 220 x 176. Write the size only while the stream is idle. Writes do not
// move the position counters.
// ----------------------------------------------------------------------------
module ordered_dither_rgb666
	import od666_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	od666_pix_if.sink            pix_in,
	od666_lvl_if.source          pix_out
);
	// size registers
	logic [CNT_W-1:0] frame_width_q, frame_height_q;

	// stage 1: captured pixel and its position
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	pos_t             pos_s1;

	// result register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] blue_q, green_q, red_q;
	logic               eor_q, eof_q;

	pos_t               pos_cur;
	logic               in_xfer, adv_s1;
	logic [1:0]         thr;
	logic [LEVEL_W-1:0] blue_d, green_d, red_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1       = !out_valid_q || pix_out.ready;
	assign pix_in.ready = !valid_s1 || adv_s1;
	assign in_xfer      = pix_in.valid && pix_in.ready;

	od666_pos u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_xfer),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pos          (pos_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pixel_s1 <= pix_in.pixel_word;
			pos_s1   <= pos_cur;
		end
	end

	// one threshold shared by all three channels of the pixel
	assign thr = dither_thr(pos_s1.row_lo, pos_s1.col_lo);

	od666_chan u_blue (
		.value (pixel_s1[7:0]),
		.thr   (thr),
		.level (blue_d)
	);

	od666_chan u_green (
		.value (pixel_s1[15:8]),
		.thr   (thr),
		.level (green_d)
	);

	od666_chan u_red (
		.value (pixel_s1[23:16]),
		.thr   (thr),
		.level (red_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			blue_q  <= blue_d;
			green_q <= green_d;
			red_q   <= red_d;
			eor_q   <= pos_s1.eor;
			eof_q   <= pos_s1.eof;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.blue_level   = blue_q;
	assign pix_out.green_level  = green_q;
	assign pix_out.red_level    = red_q;
	assign pix_out.end_of_row   = eor_q;
	assign pix_out.end_of_frame = eof_q;

	// a frame always ends on a row end
	a_eof_on_eor: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (!pix_out.end_of_frame || pix_out.end_of_row))
		else $error("end_of_frame without end_of_row");

	// input stalls only when both stages are full and the sink holds off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (valid_s1 && out_valid_q && !pix_out.ready))
		else $error("input stalled with room in the pipeline");

	// a blocked stage 1 keeps its pixel and position
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(pixel_s1) && $stable(pos_s1)))
		else $error("stage 1 lost its item while blocked");
endmodule
